### rtl/core/cma_pkg.sv
// shared types and constants of the calibrated three-axis moving average
package cma_pkg;

    // sample and register widths
    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int AXES      = 3;

    // calibration arithmetic: Q1.15 gain, round half up, then clamp
    localparam int FRAC_W = 15;
    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int QUO_W  = PROD_W - FRAC_W;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [QUO_W-1:0]  CAL_MAX    = QUO_W'(32767);
    localparam logic signed [QUO_W-1:0]  CAL_MIN    = -QUO_W'(32768);

    // a running sum needs log2(window) bits on top of a sample plus sign
    localparam int SUM_EXTRA = DATA_W + 1;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_GAIN_X   = 3'd3,
        REG_GAIN_Y   = 3'd4,
        REG_GAIN_Z   = 3'd5
    } t_reg_idx;

    // register reset values
    localparam logic signed [DATA_W-1:0] OFFSET_X_RST = 16'sd73;
    localparam logic signed [DATA_W-1:0] OFFSET_Y_RST = 16'sd18;
    localparam logic signed [DATA_W-1:0] OFFSET_Z_RST = 16'sd319;
    localparam logic [DATA_W-1:0]        GAIN_X_RST   = 16'd31470;
    localparam logic [DATA_W-1:0]        GAIN_Y_RST   = 16'd31346;
    localparam logic [DATA_W-1:0]        GAIN_Z_RST   = 16'd31798;

    // stage loads of the divider
    typedef struct packed {
        logic mag;
        logic prod;
    } t_div_ld;

endpackage

### rtl/core/cma_ram.sv
// generic single-write, single-read ram with registered read data
module cma_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/cma_cal.sv
// one-axis calibration: offset subtract, gain multiply, round and clamp
module cma_cal (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic signed [cma_pkg::DATA_W-1:0]   i_accel,
    input  logic signed [cma_pkg::DATA_W-1:0]   i_offset,
    input  logic        [cma_pkg::DATA_W-1:0]   i_gain,
    output logic signed [cma_pkg::DATA_W-1:0]   o_cal
);

    logic signed [cma_pkg::DIFF_W-1:0] diff;
    logic signed [cma_pkg::DIFF_W-1:0] gain_s;
    logic signed [cma_pkg::PROD_W-1:0] n_prod;
    logic signed [cma_pkg::PROD_W-1:0] r_prod;
    logic signed [cma_pkg::PROD_W-1:0] rnd;
    logic signed [cma_pkg::QUO_W-1:0]  quo;

    // offset subtract and gain multiply
    assign diff   = cma_pkg::DIFF_W'(i_accel) - cma_pkg::DIFF_W'(i_offset);
    assign gain_s = $signed({1'b0, i_gain});
    assign n_prod = cma_pkg::PROD_W'(diff) * cma_pkg::PROD_W'(gain_s);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    // round half up, floor shift, clamp to 16 bits
    assign rnd = r_prod + cma_pkg::ROUND_HALF;
    assign quo = rnd[cma_pkg::PROD_W-1:cma_pkg::FRAC_W];

    always_comb begin
        if (quo > cma_pkg::CAL_MAX) begin
            o_cal = cma_pkg::DATA_W'(cma_pkg::CAL_MAX);
        end else if (quo < cma_pkg::CAL_MIN) begin
            o_cal = cma_pkg::DATA_W'(cma_pkg::CAL_MIN);
        end else begin
            o_cal = quo[cma_pkg::DATA_W-1:0];
        end
    end

endmodule

### rtl/core/cma_div.sv
// one-axis divide by the window length, truncating toward zero
module cma_div #(
    parameter int WINDOW = 15
) (
    input  logic                                                i_clk,
    input  cma_pkg::t_div_ld                                    i_ld,
    input  logic signed [$clog2(WINDOW)+cma_pkg::SUM_EXTRA-1:0] i_sum,
    output logic signed [cma_pkg::DATA_W-1:0]                   o_quot
);

    localparam int LogW  = $clog2(WINDOW);
    localparam int SumW  = LogW + cma_pkg::SUM_EXTRA;
    localparam int MagW  = SumW - 1;
    localparam int MagW1 = MagW + 1;
    localparam int ProdW = MagW + MagW1;
    localparam int DivS  = MagW + LogW;
    localparam int QW    = cma_pkg::DATA_W + 1;
    // reciprocal, exact for every magnitude below 2**MagW
    localparam logic [MagW:0] DivM =
        MagW1'(((64'd1 << DivS) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [MagW-1:0]  n_mag;
    logic [MagW-1:0]  r_mag;
    logic             r_mag_neg;
    logic [ProdW-1:0] r_prod;
    logic             r_prod_neg;
    logic [QW-1:0]    q_mag;
    logic [QW-1:0]    q_signed;

    // magnitude of the sum
    always_comb begin
        if (i_sum < 0) begin
            n_mag = MagW'(-i_sum);
        end else begin
            n_mag = MagW'(i_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.mag) begin
            r_mag     <= n_mag;
            r_mag_neg <= i_sum[SumW-1];
        end
        if (i_ld.prod) begin
            r_prod     <= ProdW'(r_mag) * ProdW'(DivM);
            r_prod_neg <= r_mag_neg;
        end
    end

    // shift out the reciprocal scale and restore the sign
    assign q_mag    = QW'(r_prod >> DivS);
    assign q_signed = r_prod_neg ? (QW'(0) - q_mag) : q_mag;
    assign o_quot   = q_signed[cma_pkg::DATA_W-1:0];

endmodule

### rtl/core/calibrated_moving_average_3axis_top.sv
// top level: calibrated three-axis boxcar moving average
//
//  channel   signals                               width  moves
//  in        i_in_valid / o_in_ready               3x16   raw sample word
//  out       o_out_valid / i_out_ready             3x16+1 averaged word and full flag
//  cfg       i_cfg_wr_en, i_cfg_idx, i_cfg_data    3/16   offset or gain register
//
//  one word per cycle while the output is not stalled; each word passes in order through
//  7 stages: input, multiply, round, running sum, magnitude, reciprocal multiply, output
//  a stalled output keeps the input open until all seven stages hold a word
//  reset empties the pipeline and zeroes sums and counters; the ring needs no
//  clearing pass, slots not yet written in the first lap are read as zero
module calibrated_moving_average_3axis_top #(
    parameter int WINDOW = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [cma_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [cma_pkg::DATA_W-1:0]            i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [cma_pkg::DATA_W-1:0]     i_accel_x,
    input  logic signed [cma_pkg::DATA_W-1:0]     i_accel_y,
    input  logic signed [cma_pkg::DATA_W-1:0]     i_accel_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [cma_pkg::DATA_W-1:0]     o_avg_x,
    output logic signed [cma_pkg::DATA_W-1:0]     o_avg_y,
    output logic signed [cma_pkg::DATA_W-1:0]     o_avg_z,
    output logic                                  o_window_full
);

    localparam int DW     = cma_pkg::DATA_W;
    localparam int NAX    = cma_pkg::AXES;
    localparam int NSTG   = 7;
    localparam int SlotW  = $clog2(WINDOW);
    localparam int SeenW  = $clog2(WINDOW + 1);
    localparam int SumW   = SlotW + cma_pkg::SUM_EXTRA;
    localparam int RamW   = NAX * DW;

    // pipeline handshake
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] load;
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_v;

    // configuration
    logic signed [DW-1:0] r_offset [NAX];
    logic        [DW-1:0] r_gain   [NAX];

    // datapath
    logic signed [DW-1:0]   in_accel [NAX];
    logic signed [DW-1:0]   r_a_accel [NAX];
    logic signed [DW-1:0]   cal_val [NAX];
    logic signed [DW-1:0]   r_u_cal [NAX];
    logic signed [DW-1:0]   old_val [NAX];
    logic signed [SumW-1:0] n_sum [NAX];
    logic signed [SumW-1:0] r_sum [NAX];
    logic signed [DW-1:0]   div_q [NAX];
    logic signed [DW-1:0]   r_o_avg [NAX];
    logic [RamW-1:0]        ram_wdata;
    logic [RamW-1:0]        ram_rdata;
    cma_pkg::t_div_ld       div_ld;

    // ring pointers and fill tracking
    logic [SlotW-1:0] r_rd_slot;
    logic [SlotW-1:0] n_rd_slot;
    logic [SlotW-1:0] r_u_slot;
    logic [SeenW-1:0] r_seen;
    logic             r_u_fresh;
    logic             r_u_full;
    logic             r_d_full;
    logic             r_m_full;
    logic             r_p_full;
    logic             r_o_full;

    // ready chain and stage loads
    always_comb begin
        rdy[NSTG] = i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        load[0] = i_in_valid && rdy[0];
        for (int k = 1; k < NSTG; k++) begin
            load[k] = r_v[k-1] && rdy[k];
        end
        for (int k = 0; k < NSTG; k++) begin
            n_v[k] = load[k] || (r_v[k] && !rdy[k+1]);
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset[0] <= cma_pkg::OFFSET_X_RST;
            r_offset[1] <= cma_pkg::OFFSET_Y_RST;
            r_offset[2] <= cma_pkg::OFFSET_Z_RST;
            r_gain[0]   <= cma_pkg::GAIN_X_RST;
            r_gain[1]   <= cma_pkg::GAIN_Y_RST;
            r_gain[2]   <= cma_pkg::GAIN_Z_RST;
        end else if (i_cfg_wr_en) begin
            unique case (cma_pkg::t_reg_idx'(i_cfg_idx))
                cma_pkg::REG_OFFSET_X: r_offset[0] <= i_cfg_data;
                cma_pkg::REG_OFFSET_Y: r_offset[1] <= i_cfg_data;
                cma_pkg::REG_OFFSET_Z: r_offset[2] <= i_cfg_data;
                cma_pkg::REG_GAIN_X:   r_gain[0]   <= i_cfg_data;
                cma_pkg::REG_GAIN_Y:   r_gain[1]   <= i_cfg_data;
                cma_pkg::REG_GAIN_Z:   r_gain[2]   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_accel[0] = i_accel_x;
    assign in_accel[1] = i_accel_y;
    assign in_accel[2] = i_accel_z;

    // input register
    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_a_accel <= in_accel;
        end
    end

    // ring slot pointer advances as a word enters the sum stage
    assign n_rd_slot = (r_rd_slot == SlotW'(WINDOW - 1)) ? '0 : r_rd_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_slot <= '0;
            r_seen    <= '0;
        end else if (load[2]) begin
            r_rd_slot <= n_rd_slot;
            if (r_seen < SeenW'(WINDOW)) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

    // sum stage payload
    always_ff @(posedge i_clk) begin
        if (load[2]) begin
            r_u_cal   <= cal_val;
            r_u_slot  <= r_rd_slot;
            r_u_fresh <= (r_seen < SeenW'(WINDOW));
            r_u_full  <= (r_seen >= SeenW'(WINDOW - 1));
        end
    end

    assign ram_wdata = {r_u_cal[2], r_u_cal[1], r_u_cal[0]};

    cma_ram #(
        .WIDTH (RamW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (load[3]),
        .i_waddr (r_u_slot),
        .i_wdata (ram_wdata),
        .i_re    (load[2]),
        .i_raddr (r_rd_slot),
        .o_rdata (ram_rdata)
    );

    assign div_ld.mag  = load[4];
    assign div_ld.prod = load[5];

    // per-axis calibration, running sum and divide
    for (genvar a = 0; a < NAX; a++) begin : g_axis
        cma_cal u_cal (
            .i_clk    (i_clk),
            .i_load   (load[1]),
            .i_accel  (r_a_accel[a]),
            .i_offset (r_offset[a]),
            .i_gain   (r_gain[a]),
            .o_cal    (cal_val[a])
        );

        // first lap reads unwritten slots as zero
        assign old_val[a] = r_u_fresh ? '0 : ram_rdata[a*DW +: DW];
        assign n_sum[a]   = r_sum[a] - SumW'(old_val[a]) + SumW'(r_u_cal[a]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum[a] <= '0;
            end else if (load[3]) begin
                r_sum[a] <= n_sum[a];
            end
        end

        cma_div #(
            .WINDOW (WINDOW)
        ) u_div (
            .i_clk  (i_clk),
            .i_ld   (div_ld),
            .i_sum  (r_sum[a]),
            .o_quot (div_q[a])
        );
    end

    // full flag follows its word down the pipeline
    always_ff @(posedge i_clk) begin
        if (load[3]) begin
            r_d_full <= r_u_full;
        end
        if (load[4]) begin
            r_m_full <= r_d_full;
        end
        if (load[5]) begin
            r_p_full <= r_m_full;
        end
        if (load[6]) begin
            r_o_avg  <= div_q;
            r_o_full <= r_p_full;
        end
    end

    assign o_in_ready    = rdy[0];
    assign o_out_valid   = r_v[NSTG-1];
    assign o_avg_x       = r_o_avg[0];
    assign o_avg_y       = r_o_avg[1];
    assign o_avg_z       = r_o_avg[2];
    assign o_window_full = r_o_full;

endmodule

### rtl/core/cma_chk.sv
// port-level checks of the moving average, bound to the top level
module cma_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [cma_pkg::DATA_W-1:0] o_avg_x,
    input logic signed [cma_pkg::DATA_W-1:0] o_avg_y,
    input logic signed [cma_pkg::DATA_W-1:0] o_avg_z,
    input logic                              o_window_full
);

    localparam logic [3:0] MaxPend = 4'd7;

    logic       in_acc;
    logic       out_acc;
    logic [3:0] r_pend;
    logic [3:0] n_pend;
    logic       r_full_seen;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign n_pend  = r_pend + {3'd0, in_acc} - {3'd0, out_acc};

    // words in flight and whether a full window was already delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_full_seen <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (out_acc && o_window_full) begin
                r_full_seen <= 1'b1;
            end
        end
    end

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_avg_x) && $stable(o_avg_y)
            && $stable(o_avg_z) && $stable(o_window_full))
        else $error("output word changed while stalled");

    // no result without a word taken for it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 4'd0)
        else $error("output word with no input word in flight");

    // the pipeline never holds more words than it has stages
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= MaxPend)
        else $error("more words in flight than pipeline stages");

    // once the window is full it stays full
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_full_seen |-> o_window_full)
        else $error("window full flag dropped");

endmodule

bind calibrated_moving_average_3axis_top cma_chk u_cma_chk (.*);
